>>> hdl/gha_pkg.sv
// shared types and constants of the generational handle allocator
`default_nettype none
package gha_pkg;

	localparam int SLOT_W       = 8;
	localparam int GEN_W        = 32;
	localparam int CAPACITY_DEF = 256;
	localparam int GEN_BITS_DEF = 32;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic load;
		logic commit;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

>>> hdl/gha_ctrl.sv
// sequencer: read cycle, then check and write-back cycle
`default_nettype none
module gha_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output gha_pkg::ctrl_cmd_t      cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
					done_q <= 1'b0;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load   = start && (state_q == S_IDLE);
		cmd.commit = (state_q == S_EXEC);
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

endmodule
`default_nettype wire

>>> hdl/gha_datapath.sv
// generation memory, free stack, counters and handle check
`default_nettype none
module gha_datapath #(
	parameter int CAPACITY = gha_pkg::CAPACITY_DEF,
	parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gha_pkg::ctrl_cmd_t          cmd,
	input  wire logic [1:0]                  operation,
	input  wire logic [gha_pkg::SLOT_W-1:0]  slot_index,
	input  wire logic [gha_pkg::GEN_W-1:0]   generation,
	output logic [1:0]                       status,
	output logic [gha_pkg::SLOT_W-1:0]       result_slot,
	output logic [gha_pkg::GEN_W-1:0]        result_generation
);

	localparam int PW    = gha_pkg::SLOT_W;
	localparam int GW    = gha_pkg::GEN_W;
	localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMPW  = (PW > CNT_W) ? PW : CNT_W;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// generation word: live flag on top
	logic [GEN_BITS:0]      gen_mem [CAPACITY];
	// free stack word: slot and the generation it will carry when reissued
	logic [SW+GEN_BITS-1:0] stk_mem [CAPACITY];

	logic [1:0]             op_q;
	logic [PW-1:0]          slot_q;
	logic [GW-1:0]          gen_q;
	logic [GEN_BITS:0]      grd_q;
	logic [SW+GEN_BITS-1:0] srd_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       hw_q;
	logic [1:0]             status_q;
	logic [PW-1:0]          rslot_q;
	logic [GW-1:0]          rgen_q;

	logic [CMPW-1:0]        slot_in_w;
	logic [CMPW-1:0]        slot_q_w;
	logic [CNT_W-1:0]       cnt_m1;
	logic                   valid;
	logic [GEN_BITS-1:0]    gen_next;

	logic [1:0]             n_status;
	logic [CMPW-1:0]        n_slot;
	logic [GEN_BITS-1:0]    n_gen;
	logic                   gwe;
	logic [SW-1:0]          gaddr;
	logic [GEN_BITS:0]      gdata;
	logic                   swe;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       hw_d;

	assign slot_in_w = CMPW'(slot_index);
	assign slot_q_w  = CMPW'(slot_q);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign gen_next  = grd_q[GEN_BITS-1:0] + GEN_BITS'(1);

	// slots at or above the high water mark were never written, so never read as live
	assign valid = (slot_q_w < CMPW'(hw_q)) && grd_q[GEN_BITS]
		&& (GW'(grd_q[GEN_BITS-1:0]) == gen_q);

	always_comb begin
		n_status = gha_pkg::ST_INVALID;
		n_slot   = '0;
		n_gen    = '0;
		gwe      = 1'b0;
		gaddr    = slot_q_w[SW-1:0];
		gdata    = {1'b0, gen_next};
		swe      = 1'b0;
		count_d  = count_q;
		hw_d     = hw_q;
		case (op_q)
			gha_pkg::OP_CREATE: begin
				if (count_q != '0) begin
					n_status = gha_pkg::ST_OK;
					n_slot   = CMPW'(srd_q[SW+GEN_BITS-1:GEN_BITS]);
					n_gen    = srd_q[GEN_BITS-1:0];
					gwe      = 1'b1;
					gaddr    = srd_q[SW+GEN_BITS-1:GEN_BITS];
					gdata    = {1'b1, srd_q[GEN_BITS-1:0]};
					count_d  = cnt_m1;
				end else if (hw_q < CAP_CNT) begin
					// first issue of a fresh slot: generation starts at zero
					n_status = gha_pkg::ST_OK;
					n_slot   = CMPW'(hw_q);
					gwe      = 1'b1;
					gaddr    = hw_q[SW-1:0];
					gdata    = {1'b1, {GEN_BITS{1'b0}}};
					hw_d     = hw_q + CNT_W'(1);
				end else begin
					n_status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::OP_LOOKUP: begin
				if (valid) begin
					n_status = gha_pkg::ST_OK;
					n_slot   = slot_q_w;
					n_gen    = grd_q[GEN_BITS-1:0];
				end
			end
			gha_pkg::OP_REMOVE: begin
				if (valid && (count_q < CAP_CNT)) begin
					n_status = gha_pkg::ST_OK;
					n_slot   = slot_q_w;
					n_gen    = grd_q[GEN_BITS-1:0];
					gwe      = 1'b1;
					swe      = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end
			end
			default: begin
				n_status = gha_pkg::ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && gwe) gen_mem[gaddr] <= gdata;
		if (cmd.load) grd_q <= gen_mem[slot_in_w[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && swe) stk_mem[count_q[SW-1:0]] <= {slot_q_w[SW-1:0], gen_next};
		if (cmd.load) srd_q <= stk_mem[cnt_m1[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			slot_q <= slot_index;
			gen_q  <= generation;
		end
		if (cmd.commit) begin
			status_q <= n_status;
			rslot_q  <= n_slot[PW-1:0];
			rgen_q   <= GW'(n_gen);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hw_q    <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			hw_q    <= hw_d;
		end
	end

	assign status            = status_q;
	assign result_slot       = rslot_q;
	assign result_generation = rgen_q;

endmodule
`default_nettype wire

>>> hdl/generational_handle_allocator_top.sv
// top level of the generational handle allocator
// Each operation has a read and a check cycle: the transfer edge reads the slot's
// generation word and the top of the free stack, the check cycle checks the handle and
// writes back the memory words that the operation changes; the result is on the outputs
// with done in the cycle after it. busy is high only in the check cycle, and a start is
// ignored while busy but taken in the very cycle a result is shown. The receiver cannot
// stall: capture status, result_slot and result_generation whenever done is high.
// No clearing pass is needed after reset; slots are initialized on first issue.
`default_nettype none
module generational_handle_allocator_top #(
	parameter int CAPACITY = gha_pkg::CAPACITY_DEF,
	parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  operation,
	input  wire logic [gha_pkg::SLOT_W-1:0]  slot_index,
	input  wire logic [gha_pkg::GEN_W-1:0]   generation,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [gha_pkg::SLOT_W-1:0]       result_slot,
	output logic [gha_pkg::GEN_W-1:0]        result_generation
);

	gha_pkg::ctrl_cmd_t cmd;

	gha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	gha_datapath #(
		.CAPACITY (CAPACITY),
		.GEN_BITS (GEN_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.operation         (operation),
		.slot_index        (slot_index),
		.generation        (generation),
		.status            (status),
		.result_slot       (result_slot),
		.result_generation (result_generation)
	);

endmodule
`default_nettype wire

>>> hdl/gha_checker.sv
// port-level checks of the allocator and their bind
`default_nettype none
module gha_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic [1:0]                  status,
	input wire logic [gha_pkg::SLOT_W-1:0]  result_slot,
	input wire logic [gha_pkg::GEN_W-1:0]   result_generation
);

	// a transfer always yields the check cycle (busy) and then exactly one result (done)
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 done)
		else $error("accepted operation did not produce a result on time");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("check cycle not followed by result");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != gha_pkg::ST_OK) |-> (result_slot == '0)
			&& (result_generation == '0))
		else $error("failed operation returned a nonzero handle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == gha_pkg::ST_OK) || (status == gha_pkg::ST_FULL)
			|| (status == gha_pkg::ST_INVALID))
		else $error("undefined status code");

endmodule

bind generational_handle_allocator_top gha_checker u_chk (.*);
`default_nettype wire
